FILE: rtl/assert_macros.svh
// Assertion macros for the RTL files of the gravity step block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, off while reset is asserted.
`define BGS_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Condition that must never be seen at a clock edge.
`define BGS_NEVER(label, expr, msg) \
	`BGS_ASSERT(label, !(expr), msg)

`endif

FILE: rtl/bgs_pkg.sv
// Package: widths, codes, shared unit types and saturation helper.
`default_nettype none
package bgs_pkg;

	localparam int unsigned W_OP      = 3;
	localparam int unsigned W_RAD     = 26;
	localparam int unsigned W_DT      = 16;
	localparam int unsigned W_CFG_IDX = 3;
	localparam int unsigned W_ALU     = 128;
	localparam int unsigned W_D       = 35;   // signed center difference
	localparam int unsigned W_R2      = 70;   // squared distance
	localparam int unsigned W_ROOT    = 35;   // integer square root
	localparam int unsigned W_SREM    = 38;   // square root remainder
	localparam int unsigned W_DEN     = 105;  // r^2 * r
	localparam int unsigned W_DREM    = 106;  // divider remainder
	localparam int unsigned W_GMDT    = 53;   // 20 * mass * dt
	localparam int unsigned W_QUO     = 33;   // quotient before the cap
	localparam int unsigned W_CNT     = 6;

	localparam logic [W_CNT-1:0] N_BITS_D    = 6'd35;
	localparam logic [W_CNT-1:0] N_BITS_ROOT = 6'd35;
	localparam logic [W_CNT-1:0] N_BITS_DT   = 6'd16;
	localparam logic [W_CNT-1:0] N_BITS_SUMR = 6'd27;
	localparam logic [W_CNT-1:0] N_BITS_RAD  = 6'd26;
	localparam logic [W_CNT-1:0] N_BITS_QUO  = 6'd33;

	localparam logic [4:0]       GRAV_CONST = 5'd20;
	localparam logic [W_RAD-1:0] ONE_Q16    = 26'h001_0000;
	localparam logic [W_QUO-1:0] PULL_CAP   = 33'h1_0000_0000;

	typedef enum logic [W_OP-1:0] {
		OP_GRAVITY = 3'd0,
		OP_MOVE    = 3'd1,
		OP_COLLIDE = 3'd2,
		OP_POINT   = 3'd3,
		OP_RESTART = 3'd4
	} op_t;

	typedef enum logic [W_CFG_IDX-1:0] {
		CFG_START_X     = 3'd0,
		CFG_START_Y     = 3'd1,
		CFG_START_VX    = 3'd2,
		CFG_START_VY    = 3'd3,
		CFG_BODY_MASS   = 3'd4,
		CFG_BODY_RADIUS = 3'd5
	} cfg_idx_t;

	typedef struct packed {
		logic [W_ALU-1:0] a;
		logic [W_ALU-1:0] b;
		logic             sub;
	} alu_req_t;

	typedef struct packed {
		logic [W_ALU-1:0] sum;
		logic             ge;
	} alu_res_t;

	function automatic logic signed [31:0] sat32(input logic signed [W_D-1:0] v);
		logic signed [W_D-1:0] hi_lim;
		logic signed [W_D-1:0] lo_lim;
		hi_lim = W_D'(64'sh7FFF_FFFF);
		lo_lim = -W_D'(64'sh8000_0000);
		if (v > hi_lim) begin
			return 32'sh7FFF_FFFF;
		end else if (v < lo_lim) begin
			return 32'sh8000_0000;
		end
		return v[31:0];
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bgs_if.sv
// Interfaces: input item channel and result item channel.
`default_nettype none
interface bgs_in_if;
	import bgs_pkg::*;
	logic                    valid;
	logic                    ready;
	logic [W_OP-1:0]         operation;
	logic signed [31:0]      other_x;
	logic signed [31:0]      other_y;
	logic [31:0]             other_mass;
	logic [W_RAD-1:0]        other_radius;
	logic [W_DT-1:0]         dt;

	modport source (output valid, operation, other_x, other_y, other_mass,
		other_radius, dt, input ready);
	modport sink (input valid, operation, other_x, other_y, other_mass,
		other_radius, dt, output ready);
endinterface

interface bgs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] vel_x;
	logic signed [31:0] vel_y;
	logic               hit;
	logic               pull_skipped;

	modport source (output valid, pos_x, pos_y, vel_x, vel_y, hit, pull_skipped,
		input ready);
	modport sink (input valid, pos_x, pos_y, vel_x, vel_y, hit, pull_skipped,
		output ready);
endinterface
`default_nettype wire

FILE: rtl/bgs_alu.sv
// Shared 128-bit add/subtract unit with unsigned greater-or-equal flag.
`default_nettype none
module bgs_alu (
	input  bgs_pkg::alu_req_t req,
	output bgs_pkg::alu_res_t res
);
	import bgs_pkg::*;

	logic [W_ALU:0] full;

	// subtract as a + ~b + 1; carry out means a >= b
	assign full = {1'b0, req.a} + {1'b0, (req.sub ? ~req.b : req.b)}
		+ {{W_ALU{1'b0}}, req.sub};
	assign res.sum = full[W_ALU-1:0];
	assign res.ge  = full[W_ALU];

endmodule
`default_nettype wire

FILE: rtl/body_gravity_step.sv
// Top level: one body's position/velocity with gravity, move and hit tests.
// Throughput: one item at a time; the next item is taken once the result is
//   in the output register. Multiply, root, divide and compare share one 128-bit adder.
// Reset: asynchronous, active low; state clears to zero, radius to 1.0.
`default_nettype none
module body_gravity_step (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          cfg_we,
	input  wire logic [bgs_pkg::W_CFG_IDX-1:0] cfg_index,
	input  wire logic [31:0]                   cfg_data,
	bgs_in_if.sink                             in_ch,
	bgs_out_if.source                          out_ch
);
	import bgs_pkg::*;
	`include "assert_macros.svh"

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SETUP,
		ST_MUL,
		ST_SQRT,
		ST_SKIPCHK,
		ST_DIVCHK,
		ST_DIV,
		ST_APPLY,
		ST_CMP,
		ST_DONE
	} state_t;

	// what to do once the running multiply finishes
	typedef enum logic [2:0] {
		STEP_DX2,
		STEP_DY2,
		STEP_LIM2,
		STEP_DEN,
		STEP_MD,
		STEP_NUM,
		STEP_MOVE_X,
		STEP_MOVE_Y
	} step_t;

	// Configuration registers. Body mass cancels out of the pull, so the
	// write to that index is taken and dropped.
	logic signed [31:0] start_x_q, start_y_q, start_vx_q, start_vy_q;
	logic [W_RAD-1:0]   body_radius_q;

	// body state
	logic signed [31:0] pos_x_q, pos_y_q, vel_x_q, vel_y_q;

	// captured item
	op_t                op_q;
	logic signed [31:0] ox_q, oy_q;
	logic [31:0]        omass_q;
	logic [W_RAD-1:0]   orad_q;
	logic [W_DT-1:0]    dt_q;

	// sequencer and datapath
	state_t              state_q;
	step_t               step_q;
	logic [W_CNT-1:0]    cnt_q;
	logic                axis_q;
	logic signed [W_D-1:0] dx_q, dy_q;
	logic [W_ALU-1:0]    acc_q, mca_q;
	logic [W_D-1:0]      mcb_q;
	logic [W_R2-1:0]     r2_q, ssrc_q;
	logic [W_ROOT-1:0]   root_q;
	logic [W_SREM-1:0]   srem_q;
	logic [W_DEN-1:0]    den_q;
	logic [W_GMDT-1:0]   gmdt_q;
	logic [W_DREM-1:0]   drem_q;
	logic [W_QUO-1:0]    nlo_q, quo_q;
	logic                hit_q, skip_q;

	// output register
	logic               out_valid_q;
	logic signed [31:0] out_pos_x_q, out_pos_y_q, out_vel_x_q, out_vel_y_q;
	logic               out_hit_q, out_skip_q;

	alu_req_t alu_req;
	alu_res_t alu_res;

	bgs_alu u_alu (
		.req (alu_req),
		.res (alu_res)
	);

	// ---------------- combinational helpers ----------------
	logic [W_RAD-1:0]      br_w;
	logic signed [W_D-1:0] cx_w, cy_w, dx_w, dy_w;
	logic [W_D-1:0]        orad_sel_w;
	logic [W_D-1:0]        adx_w, ady_w;
	logic [W_ALU-1:0]      acc_nx;
	logic [W_GMDT-1:0]     gmdt_w;
	logic signed [31:0]    mv_step_w, pos_sel_w, mv_pos_w;
	logic signed [W_D-1:0] mv_sum_w;
	logic [W_QUO-1:0]      mag_w;
	logic signed [W_D-1:0] vel_sum_w;
	logic signed [31:0]    vel_new_w, vel_sel_w;
	logic                  dneg_w;
	logic [W_SREM-1:0]     sq_a_w;
	logic [W_SREM-1:0]     sq_b_w;
	logic                  out_free_w;

	// a radius below one unit acts as one unit
	assign br_w = (body_radius_q < ONE_Q16) ? ONE_Q16 : body_radius_q;
	assign cx_w = W_D'(pos_x_q) + W_D'(br_w);
	assign cy_w = W_D'(pos_y_q) + W_D'(br_w);
	// the point test uses the point itself; the other tests its disc center
	assign orad_sel_w = (op_q == OP_POINT) ? '0 : W_D'(orad_q);
	assign dx_w = W_D'(ox_q) + $signed(orad_sel_w) - cx_w;
	assign dy_w = W_D'(oy_q) + $signed(orad_sel_w) - cy_w;
	assign adx_w = dx_q[W_D-1] ? W_D'(-dx_q) : W_D'(dx_q);
	assign ady_w = dy_q[W_D-1] ? W_D'(-dy_q) : W_D'(dy_q);

	// accumulator after this multiply step
	assign acc_nx = mcb_q[0] ? alu_res.sum : acc_q;
	assign gmdt_w = W_GMDT'(acc_nx[47:0]) * W_GMDT'(GRAV_CONST);

	// move: floor(vel * dt / 2^16) is bits 47:16 of the signed product
	assign mv_step_w = acc_nx[47:16];
	assign pos_sel_w = (step_q == STEP_MOVE_Y) ? pos_y_q : pos_x_q;
	assign mv_sum_w  = W_D'(pos_sel_w) + W_D'(mv_step_w);
	assign mv_pos_w  = sat32(mv_sum_w);

	// pull: cap the magnitude at 2^32, then add with the sign of d
	assign mag_w     = (quo_q > PULL_CAP) ? PULL_CAP : quo_q;
	assign dneg_w    = axis_q ? dy_q[W_D-1] : dx_q[W_D-1];
	assign vel_sel_w = axis_q ? vel_y_q : vel_x_q;
	assign vel_sum_w = dneg_w ? (W_D'(vel_sel_w) - $signed(W_D'(mag_w)))
		: (W_D'(vel_sel_w) + $signed(W_D'(mag_w)));
	assign vel_new_w = sat32(vel_sum_w);

	// square root step: bring down the next bit pair, try (root << 2) | 1
	assign sq_a_w = {srem_q[W_SREM-3:0], ssrc_q[W_R2-1 -: 2]};
	assign sq_b_w = W_SREM'({root_q, 2'b01});

	assign out_free_w = !out_valid_q || out_ch.ready;

	// operand select for the shared unit
	always_comb begin
		alu_req = '0;
		case (state_q)
			ST_MUL: begin
				alu_req.a = acc_q;
				alu_req.b = mca_q;
			end
			ST_SQRT: begin
				alu_req.a   = W_ALU'(sq_a_w);
				alu_req.b   = W_ALU'(sq_b_w);
				alu_req.sub = 1'b1;
			end
			ST_SKIPCHK: begin
				alu_req.a   = W_ALU'(orad_q);
				alu_req.b   = W_ALU'(root_q);
				alu_req.sub = 1'b1;
			end
			ST_DIVCHK: begin
				// quotient reaches 2^33 when (num >> 33) >= den
				alu_req.a   = {1'b0, acc_q[W_ALU-1:1]};
				alu_req.b   = W_ALU'(den_q);
				alu_req.sub = 1'b1;
			end
			ST_DIV: begin
				alu_req.a   = W_ALU'({drem_q[W_DREM-2:0], nlo_q[W_QUO-1]});
				alu_req.b   = W_ALU'(den_q);
				alu_req.sub = 1'b1;
			end
			ST_CMP: begin
				alu_req.a   = acc_q;
				alu_req.b   = W_ALU'(r2_q);
				alu_req.sub = 1'b1;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	assign in_ch.ready = (state_q == ST_IDLE);

	// ---------------- configuration ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_x_q     <= '0;
			start_y_q     <= '0;
			start_vx_q    <= '0;
			start_vy_q    <= '0;
			body_radius_q <= ONE_Q16;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_START_X:     start_x_q     <= cfg_data;
				CFG_START_Y:     start_y_q     <= cfg_data;
				CFG_START_VX:    start_vx_q    <= cfg_data;
				CFG_START_VY:    start_vy_q    <= cfg_data;
				CFG_BODY_RADIUS: body_radius_q <= cfg_data[W_RAD-1:0];
				default: begin
				end
			endcase
		end
	end

	// ---------------- sequencer and datapath ----------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= STEP_DX2;
			cnt_q       <= '0;
			axis_q      <= 1'b0;
			out_valid_q <= 1'b0;
			pos_x_q     <= '0;
			pos_y_q     <= '0;
			vel_x_q     <= '0;
			vel_y_q     <= '0;
		end else begin
			// drop the result once the sink takes it
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						op_q    <= op_t'(in_ch.operation);
						ox_q    <= in_ch.other_x;
						oy_q    <= in_ch.other_y;
						omass_q <= in_ch.other_mass;
						orad_q  <= in_ch.other_radius;
						dt_q    <= in_ch.dt;
						state_q <= ST_SETUP;
					end
				end
				ST_SETUP: begin
					hit_q  <= 1'b0;
					skip_q <= 1'b0;
					dx_q   <= dx_w;
					dy_q   <= dy_w;
					acc_q  <= '0;
					case (op_q)
						OP_GRAVITY, OP_COLLIDE, OP_POINT: begin
							mca_q   <= W_ALU'(dx_w[W_D-1] ? W_D'(-dx_w) : W_D'(dx_w));
							mcb_q   <= dx_w[W_D-1] ? W_D'(-dx_w) : W_D'(dx_w);
							cnt_q   <= N_BITS_D;
							step_q  <= STEP_DX2;
							state_q <= ST_MUL;
						end
						OP_MOVE: begin
							mca_q   <= W_ALU'(signed'(vel_x_q));
							mcb_q   <= W_D'(dt_q);
							cnt_q   <= N_BITS_DT;
							step_q  <= STEP_MOVE_X;
							state_q <= ST_MUL;
						end
						OP_RESTART: begin
							pos_x_q <= start_x_q;
							pos_y_q <= start_y_q;
							vel_x_q <= start_vx_q;
							vel_y_q <= start_vy_q;
							state_q <= ST_DONE;
						end
						default: begin
							// unknown code: report the state unchanged
							state_q <= ST_DONE;
						end
					endcase
				end
				ST_MUL: begin
					// shift-add: one multiplier bit a cycle
					acc_q <= acc_nx;
					mca_q <= {mca_q[W_ALU-2:0], 1'b0};
					mcb_q <= {1'b0, mcb_q[W_D-1:1]};
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == W_CNT'(1)) begin
						case (step_q)
							STEP_DX2: begin
								// keep the sum running into dy^2
								mca_q  <= W_ALU'(ady_w);
								mcb_q  <= ady_w;
								cnt_q  <= N_BITS_D;
								step_q <= STEP_DY2;
							end
							STEP_DY2: begin
								r2_q  <= acc_nx[W_R2-1:0];
								acc_q <= '0;
								if (op_q == OP_COLLIDE) begin
									mca_q  <= W_ALU'(W_D'(br_w) + W_D'(orad_q));
									mcb_q  <= W_D'(br_w) + W_D'(orad_q);
									cnt_q  <= N_BITS_SUMR;
									step_q <= STEP_LIM2;
								end else if (op_q == OP_POINT) begin
									mca_q  <= W_ALU'(br_w);
									mcb_q  <= W_D'(br_w);
									cnt_q  <= N_BITS_RAD;
									step_q <= STEP_LIM2;
								end else begin
									ssrc_q  <= acc_nx[W_R2-1:0];
									srem_q  <= '0;
									root_q  <= '0;
									cnt_q   <= N_BITS_ROOT;
									state_q <= ST_SQRT;
								end
							end
							STEP_LIM2: begin
								state_q <= ST_CMP;
							end
							STEP_DEN: begin
								den_q  <= acc_nx[W_DEN-1:0];
								acc_q  <= '0;
								mca_q  <= W_ALU'(omass_q);
								mcb_q  <= W_D'(dt_q);
								cnt_q  <= N_BITS_DT;
								step_q <= STEP_MD;
							end
							STEP_MD: begin
								gmdt_q <= gmdt_w;
								acc_q  <= '0;
								mca_q  <= W_ALU'(gmdt_w);
								mcb_q  <= adx_w;
								cnt_q  <= N_BITS_D;
								axis_q <= 1'b0;
								step_q <= STEP_NUM;
							end
							STEP_NUM: begin
								// numerator is this product shifted up 32 bits
								state_q <= ST_DIVCHK;
							end
							STEP_MOVE_X: begin
								pos_x_q <= mv_pos_w;
								acc_q   <= '0;
								mca_q   <= W_ALU'(signed'(vel_y_q));
								mcb_q   <= W_D'(dt_q);
								cnt_q   <= N_BITS_DT;
								step_q  <= STEP_MOVE_Y;
							end
							STEP_MOVE_Y: begin
								pos_y_q <= mv_pos_w;
								state_q <= ST_DONE;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_SQRT: begin
					ssrc_q <= {ssrc_q[W_R2-3:0], 2'b00};
					cnt_q  <= cnt_q - 1'b1;
					if (alu_res.ge) begin
						srem_q <= alu_res.sum[W_SREM-1:0];
						root_q <= {root_q[W_ROOT-2:0], 1'b1};
					end else begin
						srem_q <= sq_a_w;
						root_q <= {root_q[W_ROOT-2:0], 1'b0};
					end
					if (cnt_q == W_CNT'(1)) begin
						state_q <= ST_SKIPCHK;
					end
				end
				ST_SKIPCHK: begin
					if (alu_res.ge) begin
						// centers within the other radius: no pull
						skip_q  <= 1'b1;
						state_q <= ST_DONE;
					end else begin
						acc_q   <= '0;
						mca_q   <= W_ALU'(r2_q);
						mcb_q   <= W_D'(root_q);
						cnt_q   <= N_BITS_ROOT;
						step_q  <= STEP_DEN;
						state_q <= ST_MUL;
					end
				end
				ST_DIVCHK: begin
					if (alu_res.ge) begin
						quo_q   <= PULL_CAP;
						state_q <= ST_APPLY;
					end else begin
						drem_q  <= acc_q[W_DREM:1];
						nlo_q   <= {acc_q[0], {(W_QUO-1){1'b0}}};
						quo_q   <= '0;
						cnt_q   <= N_BITS_QUO;
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					// restoring division, one quotient bit a cycle
					nlo_q <= {nlo_q[W_QUO-2:0], 1'b0};
					quo_q <= {quo_q[W_QUO-2:0], alu_res.ge};
					cnt_q <= cnt_q - 1'b1;
					if (alu_res.ge) begin
						drem_q <= alu_res.sum[W_DREM-1:0];
					end else begin
						drem_q <= alu_req.a[W_DREM-1:0];
					end
					if (cnt_q == W_CNT'(1)) begin
						state_q <= ST_APPLY;
					end
				end
				ST_APPLY: begin
					if (!axis_q) begin
						vel_x_q <= vel_new_w;
						axis_q  <= 1'b1;
						acc_q   <= '0;
						mca_q   <= W_ALU'(gmdt_q);
						mcb_q   <= ady_w;
						cnt_q   <= N_BITS_D;
						step_q  <= STEP_NUM;
						state_q <= ST_MUL;
					end else begin
						vel_y_q <= vel_new_w;
						state_q <= ST_DONE;
					end
				end
				ST_CMP: begin
					hit_q   <= alu_res.ge;
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					// hold until the output register is free
					if (out_free_w) begin
						out_valid_q <= 1'b1;
						out_pos_x_q <= pos_x_q;
						out_pos_y_q <= pos_y_q;
						out_vel_x_q <= vel_x_q;
						out_vel_y_q <= vel_y_q;
						out_hit_q   <= hit_q;
						out_skip_q  <= skip_q;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.pos_x        = out_pos_x_q;
	assign out_ch.pos_y        = out_pos_y_q;
	assign out_ch.vel_x        = out_vel_x_q;
	assign out_ch.vel_y        = out_vel_y_q;
	assign out_ch.hit          = out_hit_q;
	assign out_ch.pull_skipped = out_skip_q;

	// ---------------- assertions ----------------
	`BGS_ASSERT(a_busy_after_accept, (in_ch.valid && in_ch.ready) |=> !in_ch.ready, "ready after accept")
	`BGS_NEVER(a_hit_and_skip, out_ch.valid && out_ch.hit && out_ch.pull_skipped, "hit with skip")
	`BGS_ASSERT(a_mul_count, (state_q == ST_MUL) |-> (cnt_q != '0), "multiply count empty")

endmodule
`default_nettype wire
